@@ hw/rtl/cartesian_to_spherical_defines.svh @@
// Assertion macros for the Cartesian to spherical converter.
// Used by the port checker; no other dependencies.
`ifndef CARTESIAN_TO_SPHERICAL_DEFINES_SVH
`define CARTESIAN_TO_SPHERICAL_DEFINES_SVH

// Clocked assertion, disabled while reset is asserted.
`define C2S_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Clocked assertion that is also checked during reset.
`define C2S_ASSERT_RST(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/c2s_pkg.sv @@
// Shared constants, angle table and sizing functions of the
// Cartesian to spherical converter. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package c2s_pkg;

  localparam int unsigned ANGLE_W = 16;
  localparam int unsigned ACC_W   = 32;
  localparam int unsigned ATAN_N  = 32;
  localparam int unsigned FULL_W  = 31;

  localparam logic [ACC_W-1:0]   ACC_ZERO    = 32'h0000_0000;
  localparam logic [ACC_W-1:0]   ACC_HALF_PI = 32'h4000_0000;
  localparam logic [ACC_W-1:0]   ACC_PI      = 32'h8000_0000;
  localparam logic [ACC_W-1:0]   ACC_UNDER   = 32'hC000_0000;
  localparam logic [ACC_W-1:0]   ACC_ROUND   = 32'h0000_8000;
  localparam logic [ANGLE_W-1:0] ANGLE_ZERO  = 16'h0000;
  localparam logic [ANGLE_W-1:0] ANGLE_PI    = 16'h8000;

  // atan(2^-i) in units of 2^-32 turn
  localparam logic [ACC_W-1:0] ATAN_TURN [ATAN_N] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  // left shift that brings a coordinate up to the full CORDIC scale
  function automatic int unsigned scale_shift(input int unsigned coord_w);
    return (coord_w < FULL_W) ? (FULL_W - coord_w) : 0;
  endfunction

  function automatic int unsigned cordic_len(input int unsigned stages);
    return (stages < ATAN_N) ? stages : ATAN_N;
  endfunction

  // squares, sums, root cells, rotation cells, output register
  function automatic int unsigned pipe_depth(input int unsigned coord_w,
                                             input int unsigned stages);
    return coord_w + scale_shift(coord_w) + cordic_len(stages) + 3;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/c2s_point_if.sv @@
// Request channel carrying one Cartesian point.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface c2s_point_if #(
  parameter int unsigned COORD_WIDTH = 16
) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] pos_x;
  logic signed [COORD_WIDTH-1:0] pos_y;
  logic signed [COORD_WIDTH-1:0] pos_z;

  modport source (output valid, output pos_x, output pos_y, output pos_z, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input pos_z, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/c2s_sphere_if.sv @@
// Result channel carrying one point in spherical coordinates.
// Depends on c2s_pkg for the angle width.
`timescale 1ns / 1ps
`default_nettype none

interface c2s_sphere_if #(
  parameter int unsigned COORD_WIDTH = 16
) ();
  logic                               valid;
  logic                               ready;
  logic        [COORD_WIDTH-1:0]      radius;
  logic        [c2s_pkg::ANGLE_W-1:0] polar_angle;
  logic signed [c2s_pkg::ANGLE_W-1:0] azimuth;

  modport source (output valid, output radius, output polar_angle, output azimuth,
                  input ready);
  modport sink   (input valid, input radius, input polar_angle, input azimuth,
                  output ready);
endinterface

`default_nettype wire

@@ hw/rtl/c2s_sqrt_cell.sv @@
// One digit-by-digit square root step: produces one root bit per cell.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module c2s_sqrt_cell #(
  parameter int unsigned ROOT_W = 31
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [2*ROOT_W-1:0] rad_i,
  input  logic [ROOT_W:0]     rem_i,
  input  logic [ROOT_W-1:0]   root_i,
  output logic [2*ROOT_W-1:0] rad_o,
  output logic [ROOT_W:0]     rem_o,
  output logic [ROOT_W-1:0]   root_o
);

  localparam int unsigned RAD_W = 2 * ROOT_W;
  localparam int unsigned REM_W = ROOT_W + 1;
  localparam int unsigned CUR_W = ROOT_W + 3;

  logic [CUR_W-1:0]  cur;
  logic [CUR_W-1:0]  trial;
  logic              ge;
  logic [RAD_W-1:0]  rad_d, rad_q;
  logic [REM_W-1:0]  rem_d, rem_q;
  logic [ROOT_W-1:0] root_d, root_q;

  assign cur   = {rem_i, rad_i[RAD_W-1 -: 2]};
  assign trial = CUR_W'({root_i, 2'b01});
  assign ge    = (cur >= trial);

  always_comb begin
    rad_d  = {rad_i[RAD_W-3:0], 2'b00};
    rem_d  = ge ? REM_W'(cur - trial) : REM_W'(cur);
    root_d = {root_i[ROOT_W-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q  <= rad_d;
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign rad_o  = rad_q;
  assign rem_o  = rem_q;
  assign root_o = root_q;

endmodule

`default_nettype wire

@@ hw/rtl/c2s_cordic_cell.sv @@
// One vectoring CORDIC micro-rotation with a fixed shift.
// Depends on c2s_pkg for the arctangent table.
`timescale 1ns / 1ps
`default_nettype none

module c2s_cordic_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned CW  = 34
) (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  logic signed [CW-1:0]             x_i,
  input  logic signed [CW-1:0]             y_i,
  input  logic        [c2s_pkg::ACC_W-1:0] ang_i,
  output logic signed [CW-1:0]             x_o,
  output logic signed [CW-1:0]             y_o,
  output logic        [c2s_pkg::ACC_W-1:0] ang_o
);

  logic signed [CW-1:0]             dx, dy;
  logic signed [CW-1:0]             x_d, y_d, x_q, y_q;
  logic        [c2s_pkg::ACC_W-1:0] ang_d, ang_q;

  assign dx = y_i >>> IDX;
  assign dy = x_i >>> IDX;

  always_comb begin
    if (!y_i[CW-1]) begin
      x_d   = x_i + dx;
      y_d   = y_i - dy;
      ang_d = ang_i + c2s_pkg::ATAN_TURN[IDX];
    end else begin
      x_d   = x_i - dx;
      y_d   = y_i + dy;
      ang_d = ang_i - c2s_pkg::ATAN_TURN[IDX];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q   <= x_d;
      y_q   <= y_d;
      ang_q <= ang_d;
    end
  end

  assign x_o   = x_q;
  assign y_o   = y_q;
  assign ang_o = ang_q;

endmodule

`default_nettype wire

@@ hw/rtl/cartesian_to_spherical.sv @@
// Cartesian to spherical converter, top level.
// Depends on c2s_pkg, c2s_point_if, c2s_sphere_if, c2s_sqrt_cell, c2s_cordic_cell.
//
// Converts one point (pos_x, pos_y, pos_z) per clock into radius, polar angle
// (0..32768 for 0..pi) and azimuth (binary angle, +pi reads -32768). The block
// is a single pipeline of COORD_WIDTH + max(31 - COORD_WIDTH, 0) +
// CORDIC_STAGES (at most the arctangent table length) + 3 stages: one
// squaring stage, one sum stage, a row of square root cells that each
// produce one root bit of the radius and of the xy magnitude, a row of
// CORDIC cells that each apply one micro-rotation to the azimuth and polar
// vectors side by side, and the output register. A new point is taken every
// cycle; when the result is not taken, stages still fill their empty slots
// and the input stalls only once every stage holds a point.
`timescale 1ns / 1ps
`default_nettype none

module cartesian_to_spherical #(
  parameter int unsigned COORD_WIDTH   = 16,
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  c2s_point_if.sink    point_i,
  c2s_sphere_if.source sphere_o
);

  localparam int unsigned W       = COORD_WIDTH;
  localparam int unsigned S       = c2s_pkg::scale_shift(COORD_WIDTH);
  localparam int unsigned SW      = W + S;
  localparam int unsigned CW      = SW + 3;
  localparam int unsigned RAD_W   = 2 * SW;
  localparam int unsigned NQ      = SW;
  localparam int unsigned NC      = c2s_pkg::cordic_len(CORDIC_STAGES);
  localparam int unsigned NS      = c2s_pkg::pipe_depth(COORD_WIDTH, CORDIC_STAGES);
  localparam int unsigned ST_SUM  = 1;
  localparam int unsigned ST_ROOT = 2;
  localparam int unsigned ST_CORD = NQ + 2;
  localparam int unsigned ST_OUT  = NS - 1;
  localparam int unsigned ACC_W   = c2s_pkg::ACC_W;
  localparam int unsigned ANGLE_W = c2s_pkg::ANGLE_W;

  typedef struct packed {
    logic signed [CW-1:0] ax;
    logic signed [CW-1:0] ay;
    logic [ACC_W-1:0]     aang;
    logic signed [CW-1:0] zabs;
    logic                 z_neg;
    logic                 az_zero;
    logic                 pol_zero;
  } side_t;

  typedef struct packed {
    logic [W-1:0] radius;
    logic         az_zero;
    logic         pol_zero;
  } tail_t;

  // ---------------- pipeline flow control ----------------
  logic [NS-1:0] vld_q, vld_d, load, hole, upstream;

  assign hole     = ~vld_q;
  assign upstream = {vld_q[NS-2:0], point_i.valid};

  always_comb begin
    for (int k = 0; k < NS; k++) begin
      load[k] = sphere_o.ready | (|(hole >> k));
    end
    vld_d = (upstream & load) | (vld_q & ~load);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign point_i.ready  = load[0];
  assign sphere_o.valid = vld_q[ST_OUT];

  // ---------------- squares ----------------
  logic signed [W-1:0]   x0_q, y0_q, z0_q;
  logic signed [2*W-1:0] xsq, ysq, zsq;
  logic [2*W-1:0]        xx0_q, yy0_q, zz0_q;

  always_comb begin
    xsq = point_i.pos_x * point_i.pos_x;
    ysq = point_i.pos_y * point_i.pos_y;
    zsq = point_i.pos_z * point_i.pos_z;
  end

  always_ff @(posedge clk_i) begin
    if (load[0]) begin
      x0_q  <= point_i.pos_x;
      y0_q  <= point_i.pos_y;
      z0_q  <= point_i.pos_z;
      xx0_q <= xsq;
      yy0_q <= ysq;
      zz0_q <= zsq;
    end
  end

  // ---------------- sums and CORDIC start vectors ----------------
  logic [2*W-1:0]       rho_sq_d, r_sq_d, rho_sq1_q, r_sq1_q;
  logic signed [CW-1:0] xs, ys, zs;
  side_t                side_d;
  side_t                side_q [NQ+1];

  always_comb begin
    rho_sq_d = xx0_q + yy0_q;
    r_sq_d   = rho_sq_d + zz0_q;
    xs       = CW'(x0_q) <<< S;
    ys       = CW'(y0_q) <<< S;
    zs       = CW'(z0_q) <<< S;
    if (x0_q < 0) begin
      side_d.ax   = -xs;
      side_d.ay   = -ys;
      side_d.aang = c2s_pkg::ACC_PI;
    end else begin
      side_d.ax   = xs;
      side_d.ay   = ys;
      side_d.aang = c2s_pkg::ACC_ZERO;
    end
    side_d.z_neg    = (z0_q < 0);
    side_d.zabs     = (z0_q < 0) ? -zs : zs;
    side_d.az_zero  = (x0_q == '0) && (y0_q == '0);
    side_d.pol_zero = (x0_q == '0) && (y0_q == '0) && (z0_q == '0);
  end

  always_ff @(posedge clk_i) begin
    if (load[ST_SUM]) begin
      rho_sq1_q <= rho_sq_d;
      r_sq1_q   <= r_sq_d;
      side_q[0] <= side_d;
    end
  end

  // ---------------- square root cells ----------------
  logic [RAD_W-1:0] rad_r [NQ+1];
  logic [SW:0]      rem_r [NQ+1];
  logic [SW-1:0]    root_r[NQ+1];
  logic [RAD_W-1:0] rad_p [NQ+1];
  logic [SW:0]      rem_p [NQ+1];
  logic [SW-1:0]    root_p[NQ+1];

  assign rad_r[0]  = RAD_W'(r_sq1_q) << (2 * S);
  assign rem_r[0]  = '0;
  assign root_r[0] = '0;
  assign rad_p[0]  = RAD_W'(rho_sq1_q) << (2 * S);
  assign rem_p[0]  = '0;
  assign root_p[0] = '0;

  for (genvar k = 0; k < NQ; k++) begin : g_root
    c2s_sqrt_cell #(.ROOT_W(SW)) u_rad_cell (
      .clk_i  (clk_i),
      .en_i   (load[ST_ROOT+k]),
      .rad_i  (rad_r[k]),
      .rem_i  (rem_r[k]),
      .root_i (root_r[k]),
      .rad_o  (rad_r[k+1]),
      .rem_o  (rem_r[k+1]),
      .root_o (root_r[k+1])
    );

    c2s_sqrt_cell #(.ROOT_W(SW)) u_rho_cell (
      .clk_i  (clk_i),
      .en_i   (load[ST_ROOT+k]),
      .rad_i  (rad_p[k]),
      .rem_i  (rem_p[k]),
      .root_i (root_p[k]),
      .rad_o  (rad_p[k+1]),
      .rem_o  (rem_p[k+1]),
      .root_o (root_p[k+1])
    );

    always_ff @(posedge clk_i) begin
      if (load[ST_ROOT+k]) begin
        side_q[k+1] <= side_q[k];
      end
    end
  end

  // ---------------- CORDIC cells ----------------
  side_t                side_e;
  logic signed [CW-1:0] rho_c;
  logic signed [CW-1:0] ax_c[NC+1];
  logic signed [CW-1:0] ay_c[NC+1];
  logic [ACC_W-1:0]     aa_c[NC+1];
  logic signed [CW-1:0] px_c[NC+1];
  logic signed [CW-1:0] py_c[NC+1];
  logic [ACC_W-1:0]     pa_c[NC+1];
  tail_t                tail_d;
  tail_t                tail_q[NC];

  assign side_e = side_q[NQ];
  assign rho_c  = CW'(root_p[NQ]);

  always_comb begin
    ax_c[0] = side_e.ax;
    ay_c[0] = side_e.ay;
    aa_c[0] = side_e.aang;
    if (side_e.z_neg) begin
      px_c[0] = rho_c;
      py_c[0] = side_e.zabs;
      pa_c[0] = c2s_pkg::ACC_HALF_PI;
    end else begin
      px_c[0] = side_e.zabs;
      py_c[0] = rho_c;
      pa_c[0] = c2s_pkg::ACC_ZERO;
    end
    tail_d.radius   = root_r[NQ][SW-1:S];
    tail_d.az_zero  = side_e.az_zero;
    tail_d.pol_zero = side_e.pol_zero;
  end

  for (genvar k = 0; k < NC; k++) begin : g_rot
    c2s_cordic_cell #(.IDX(k), .CW(CW)) u_az_cell (
      .clk_i (clk_i),
      .en_i  (load[ST_CORD+k]),
      .x_i   (ax_c[k]),
      .y_i   (ay_c[k]),
      .ang_i (aa_c[k]),
      .x_o   (ax_c[k+1]),
      .y_o   (ay_c[k+1]),
      .ang_o (aa_c[k+1])
    );

    c2s_cordic_cell #(.IDX(k), .CW(CW)) u_pol_cell (
      .clk_i (clk_i),
      .en_i  (load[ST_CORD+k]),
      .x_i   (px_c[k]),
      .y_i   (py_c[k]),
      .ang_i (pa_c[k]),
      .x_o   (px_c[k+1]),
      .y_o   (py_c[k+1]),
      .ang_o (pa_c[k+1])
    );

    if (k == 0) begin : g_head
      always_ff @(posedge clk_i) begin
        if (load[ST_CORD]) begin
          tail_q[0] <= tail_d;
        end
      end
    end else begin : g_body
      always_ff @(posedge clk_i) begin
        if (load[ST_CORD+k]) begin
          tail_q[k] <= tail_q[k-1];
        end
      end
    end
  end

  // ---------------- output register ----------------
  tail_t              tail_e;
  logic [ACC_W-1:0]   phi_sum, th_sum;
  logic [ANGLE_W-1:0] azim_d, polar_d, azim_q, polar_q;
  logic [W-1:0]       radius_q;

  assign tail_e = tail_q[NC-1];

  always_comb begin
    phi_sum = aa_c[NC] + c2s_pkg::ACC_ROUND;
    th_sum  = pa_c[NC] + c2s_pkg::ACC_ROUND;
    azim_d  = tail_e.az_zero ? c2s_pkg::ANGLE_ZERO : phi_sum[ACC_W-1 -: ANGLE_W];
    if (tail_e.pol_zero) begin
      polar_d = c2s_pkg::ANGLE_ZERO;
    end else if (pa_c[NC] > c2s_pkg::ACC_UNDER) begin
      polar_d = c2s_pkg::ANGLE_ZERO;
    end else if (pa_c[NC] > c2s_pkg::ACC_PI) begin
      polar_d = c2s_pkg::ANGLE_PI;
    end else begin
      polar_d = th_sum[ACC_W-1 -: ANGLE_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (load[ST_OUT]) begin
      radius_q <= tail_e.radius;
      polar_q  <= polar_d;
      azim_q   <= azim_d;
    end
  end

  assign sphere_o.radius      = radius_q;
  assign sphere_o.polar_angle = polar_q;
  assign sphere_o.azimuth     = azim_q;

endmodule

`default_nettype wire

@@ hw/rtl/c2s_checker.sv @@
// Port-level checker for cartesian_to_spherical, bound to the top level.
// Depends on c2s_pkg and cartesian_to_spherical_defines.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "cartesian_to_spherical_defines.svh"

module c2s_port_checker #(
  parameter int unsigned COORD_WIDTH   = 16,
  parameter int unsigned CORDIC_STAGES = 16
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [COORD_WIDTH-1:0]      radius_i,
  input logic [c2s_pkg::ANGLE_W-1:0] polar_angle_i,
  input logic [c2s_pkg::ANGLE_W-1:0] azimuth_i
);

  localparam int unsigned DEPTH = c2s_pkg::pipe_depth(COORD_WIDTH, CORDIC_STAGES);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic             in_acc, out_acc;
  logic [CNT_W-1:0] inflight_d, inflight_q;

  assign in_acc     = in_valid_i && in_ready_i;
  assign out_acc    = out_valid_i && out_ready_i;
  assign inflight_d = inflight_q + CNT_W'(in_acc) - CNT_W'(out_acc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_d;
    end
  end

  `C2S_ASSERT_RST(a_idle_in_reset, clk_i, (!rst_ni) |-> !out_valid_i, "result valid in reset")
  `C2S_ASSERT(a_no_orphan, clk_i, rst_ni, out_valid_i |-> (inflight_q != '0), "result without request")
  `C2S_ASSERT(a_capacity, clk_i, rst_ni, inflight_q <= CNT_W'(DEPTH), "more requests in flight than stages")
  `C2S_ASSERT(a_empty_ready, clk_i, rst_ni, (inflight_q == '0) |-> in_ready_i, "empty pipeline refuses request")
  `C2S_ASSERT(a_stall_hold, clk_i, rst_ni, (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(radius_i) && $stable(polar_angle_i) && $stable(azimuth_i)), "stalled result changed")

endmodule

bind cartesian_to_spherical c2s_port_checker #(
  .COORD_WIDTH   (COORD_WIDTH),
  .CORDIC_STAGES (CORDIC_STAGES)
) u_c2s_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (point_i.valid),
  .in_ready_i    (point_i.ready),
  .out_valid_i   (sphere_o.valid),
  .out_ready_i   (sphere_o.ready),
  .radius_i      (sphere_o.radius),
  .polar_angle_i (sphere_o.polar_angle),
  .azimuth_i     (sphere_o.azimuth)
);

`default_nettype wire

@@ dv/c2s_checker.sv @@
// Scoreboard for the Cartesian to spherical converter: predicts radius, polar
// angle and azimuth for every accepted point and compares each result in order.
// Depends on c2s_point_if and c2s_sphere_if.
`timescale 1ns / 1ps

module c2s_checker #(
  parameter int unsigned COORD_WIDTH   = 16,
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  c2s_point_if        point_i,
  c2s_sphere_if       sphere_i,
  output int unsigned error_cnt_o,
  output int unsigned pending_o
);

  localparam int unsigned SHIFT     = (COORD_WIDTH < 31) ? (31 - COORD_WIDTH) : 0;
  localparam int unsigned ROT_STEPS = (CORDIC_STAGES < 32) ? CORDIC_STAGES : 32;
  localparam longint unsigned RADIUS_MAX = (64'd1 << COORD_WIDTH) - 64'd1;

  localparam logic [31:0] TURN_HALF_PI = 32'h4000_0000;
  localparam logic [31:0] TURN_PI      = 32'h8000_0000;
  localparam logic [31:0] TURN_UNDER   = 32'hC000_0000;
  localparam logic [31:0] TURN_ROUND   = 32'h0000_8000;

  // atan(2^-i), 2^-32 turn units
  localparam logic [31:0] ARCTAN_STEP [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef struct packed {
    logic [COORD_WIDTH-1:0] radius;
    logic [15:0]            polar_angle;
    logic signed [15:0]     azimuth;
  } sphere_t;

  sphere_t     sphere_q[$];
  int unsigned errors;

  assign error_cnt_o = errors;

  function automatic longint unsigned int_sqrt(input longint unsigned val);
    longint unsigned root;
    longint unsigned rem;
    longint unsigned probe;
    root  = 0;
    rem   = val;
    probe = 64'h4000_0000_0000_0000;
    while (probe > rem) probe >>= 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem  = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe >>= 2;
    end
    return root;
  endfunction

  // vectoring rotations, shifts floor toward minus infinity
  function automatic logic [31:0] cordic_angle(input longint vx, input longint vy,
                                               input logic [31:0] start);
    logic [31:0] acc;
    longint      dx;
    longint      dy;
    acc = start;
    for (int i = 0; i < ROT_STEPS; i++) begin
      dx = vy >>> i;
      dy = vx >>> i;
      if (vy >= 0) begin
        vx  = vx + dx;
        vy  = vy - dy;
        acc = acc + ARCTAN_STEP[i];
      end else begin
        vx  = vx - dx;
        vy  = vy + dy;
        acc = acc - ARCTAN_STEP[i];
      end
    end
    return acc;
  endfunction

  function automatic sphere_t predict_sphere(input coord_t px, input coord_t py,
                                             input coord_t pz);
    longint          sx, sy, sz;
    longint          xs, ys, zs;
    longint          rho;
    longint unsigned rho_sq, r_sq, root;
    logic [31:0]     acc;
    sphere_t         res;
    sx = px;
    sy = py;
    sz = pz;
    rho_sq = longint'(sx * sx) + longint'(sy * sy);
    r_sq   = rho_sq + longint'(sz * sz);
    root   = int_sqrt(r_sq);
    if (root > RADIUS_MAX) root = RADIUS_MAX;
    res.radius = root[COORD_WIDTH-1:0];

    xs = sx <<< SHIFT;
    ys = sy <<< SHIFT;
    zs = sz <<< SHIFT;

    if (sx == 0 && sy == 0) begin
      res.azimuth = '0;
    end else begin
      if (xs < 0) acc = cordic_angle(-xs, -ys, TURN_PI);
      else        acc = cordic_angle(xs, ys, '0);
      acc = acc + TURN_ROUND;
      res.azimuth = acc[31:16];
    end

    if (r_sq == 0) begin
      res.polar_angle = '0;
    end else begin
      rho = longint'(int_sqrt(rho_sq << (2 * SHIFT)));
      if (zs < 0) acc = cordic_angle(rho, -zs, TURN_HALF_PI);
      else        acc = cordic_angle(zs, rho, '0);
      // CORDIC error can push the angle just outside 0..pi
      if (acc > TURN_UNDER) begin
        res.polar_angle = '0;
      end else if (acc > TURN_PI) begin
        res.polar_angle = 16'h8000;
      end else begin
        acc = acc + TURN_ROUND;
        res.polar_angle = acc[31:16];
      end
    end
    return res;
  endfunction

  task automatic flag_error(input string msg);
    $display("[%0t] ERROR: %s", $realtime, msg);
    errors++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    sphere_t want;
    if (!rst_ni) begin
      sphere_q.delete();
      errors    = 0;
      pending_o = 0;
    end else begin
      if (point_i.valid && point_i.ready) begin
        sphere_q.push_back(predict_sphere(point_i.pos_x, point_i.pos_y, point_i.pos_z));
      end
      if (sphere_i.valid && sphere_i.ready) begin
        if (sphere_q.size() == 0) begin
          flag_error($sformatf("unexpected result r=%0d theta=%0d phi=%0d",
                               sphere_i.radius, sphere_i.polar_angle, sphere_i.azimuth));
        end else begin
          want = sphere_q.pop_front();
          if (sphere_i.radius !== want.radius)
            flag_error($sformatf("radius %0d, expected %0d", sphere_i.radius, want.radius));
          if (sphere_i.polar_angle !== want.polar_angle)
            flag_error($sformatf("polar_angle %0d, expected %0d",
                                 sphere_i.polar_angle, want.polar_angle));
          if (sphere_i.azimuth !== want.azimuth)
            flag_error($sformatf("azimuth %0d, expected %0d",
                                 sphere_i.azimuth, want.azimuth));
        end
      end
      pending_o = sphere_q.size();
    end
  end

endmodule

@@ dv/tb.sv @@
// Testbench top for cartesian_to_spherical: drives points with random gaps,
// stalls the result side at random and gives the verdict from c2s_checker.
// Depends on c2s_pkg, c2s_point_if, c2s_sphere_if, c2s_checker and the block.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned COORD_WIDTH   = 16;
  localparam int unsigned CORDIC_STAGES = 16;
  localparam int unsigned LATENCY       = c2s_pkg::pipe_depth(COORD_WIDTH, CORDIC_STAGES);
  localparam int unsigned RAND_POINTS   = 550;
  localparam int unsigned MAX_GAP       = 14;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef enum {DRAW_FULL, DRAW_SMALL, DRAW_EDGE} draw_kind_e;

  localparam coord_t C_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
  localparam coord_t C_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};

  logic        clk_i;
  logic        rst_ni;
  int unsigned error_cnt;
  int unsigned pending;
  bit          tx_steady;
  bit          rx_steady;

  c2s_point_if  #(.COORD_WIDTH(COORD_WIDTH)) point_if ();
  c2s_sphere_if #(.COORD_WIDTH(COORD_WIDTH)) sphere_if ();

  cartesian_to_spherical #(
    .COORD_WIDTH  (COORD_WIDTH),
    .CORDIC_STAGES(CORDIC_STAGES)
  ) u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .point_i (point_if),
    .sphere_o(sphere_if)
  );

  c2s_checker #(
    .COORD_WIDTH  (COORD_WIDTH),
    .CORDIC_STAGES(CORDIC_STAGES)
  ) u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .point_i    (point_if),
    .sphere_i   (sphere_if),
    .error_cnt_o(error_cnt),
    .pending_o  (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #400000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic coord_t draw_coord(input draw_kind_e kind);
    case (kind)
      DRAW_SMALL: return coord_t'(int'($urandom_range(0, 32)) - 16);
      DRAW_EDGE: begin
        case ($urandom_range(0, 5))
          0: return C_MIN;
          1: return coord_t'(C_MIN + 1);
          2: return -1;
          3: return 0;
          4: return 1;
          default: return C_MAX;
        endcase
      end
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic int unsigned draw_gap(input bit steady);
    return steady ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  task automatic send_point(input coord_t x, input coord_t y, input coord_t z);
    int unsigned gap;
    gap = draw_gap(tx_steady);
    if (gap != 0) begin
      point_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    point_if.valid <= 1'b1;
    point_if.pos_x <= x;
    point_if.pos_y <= y;
    point_if.pos_z <= z;
    do @(posedge clk_i); while (!(point_if.valid && point_if.ready));
    @(negedge clk_i);
  endtask

  // result side: random stall before each result is taken
  initial begin
    int unsigned gap;
    int unsigned taken;
    sphere_if.ready = 1'b0;
    taken = 0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (taken % 40 == 0) rx_steady = ($urandom_range(0, 3) == 0);
      gap = draw_gap(rx_steady);
      if (gap != 0) begin
        sphere_if.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      sphere_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(sphere_if.valid && sphere_if.ready));
      taken++;
      @(negedge clk_i);
    end
  end

  initial begin
    coord_t x, y, z;
    int unsigned pick;
    point_if.valid = 1'b0;
    point_if.pos_x = '0;
    point_if.pos_y = '0;
    point_if.pos_z = '0;
    tx_steady      = 1'b0;
    rst_ni         = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // origin, axes, corners, azimuth wrap at pi, polar angle near 0 and pi
    send_point(0, 0, 0);
    send_point(0, 0, C_MAX);
    send_point(0, 0, C_MIN);
    send_point(0, 0, 1);
    send_point(0, 0, -1);
    send_point(C_MAX, 0, 0);
    send_point(C_MIN, 0, 0);
    send_point(-1, 0, 0);
    send_point(0, C_MAX, 0);
    send_point(0, C_MIN, 0);
    send_point(C_MAX, C_MAX, C_MAX);
    send_point(C_MIN, C_MIN, C_MIN);
    send_point(C_MIN, C_MAX, C_MIN);
    send_point(C_MAX, C_MIN, C_MAX);
    send_point(C_MIN, C_MIN, C_MAX);
    send_point(C_MAX, C_MAX, C_MIN);
    send_point(1, 1, 1);
    send_point(-1, -1, -1);
    send_point(1, 0, C_MAX);
    send_point(0, -1, C_MAX);
    send_point(1, 0, C_MIN);
    send_point(-1, 1, C_MIN);
    send_point(C_MIN, -1, 0);
    send_point(C_MIN, 1, 5);

    for (int n = 0; n < RAND_POINTS; n++) begin
      if (n % 50 == 0) tx_steady = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 9);
      if (pick <= 4) begin
        x = draw_coord(DRAW_FULL);
        y = draw_coord(DRAW_FULL);
        z = draw_coord(DRAW_FULL);
      end else if (pick == 5) begin
        x = draw_coord(DRAW_SMALL);
        y = draw_coord(DRAW_SMALL);
        z = draw_coord(DRAW_SMALL);
      end else if (pick == 6) begin
        x = draw_coord(DRAW_EDGE);
        y = draw_coord(DRAW_EDGE);
        z = draw_coord(DRAW_EDGE);
      end else if (pick == 7) begin
        // close to the z axis
        x = draw_coord(DRAW_SMALL);
        y = draw_coord(DRAW_SMALL);
        z = draw_coord(DRAW_FULL);
      end else if (pick == 8) begin
        // negative x near the azimuth wrap
        x = draw_coord(DRAW_FULL);
        if (x > 0) x = -x;
        y = draw_coord(DRAW_SMALL);
        z = draw_coord(DRAW_FULL);
      end else begin
        x = draw_coord(DRAW_FULL);
        y = draw_coord(DRAW_FULL);
        z = draw_coord(DRAW_FULL);
        case ($urandom_range(0, 5))
          0: x = 0;
          1: y = 0;
          2: z = 0;
          3: begin x = 0; y = 0; end
          4: begin x = 0; z = 0; end
          default: begin y = 0; z = 0; end
        endcase
      end
      send_point(x, y, z);
    end
    point_if.valid <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (LATENCY + 20) @(negedge clk_i);
    if (error_cnt == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/c2s_pkg.sv
hw/rtl/c2s_point_if.sv
hw/rtl/c2s_sphere_if.sv
hw/rtl/c2s_sqrt_cell.sv
hw/rtl/c2s_cordic_cell.sv
hw/rtl/cartesian_to_spherical.sv
hw/rtl/c2s_checker.sv
dv/c2s_checker.sv
dv/tb.sv
